// File: sv/rde_pkg.sv
`default_nettype none
package rde_pkg;

  // Default store depth
  localparam int unsigned DefaultDepth = 64;

  // Field widths
  localparam int unsigned CmdW    = 2;
  localparam int unsigned ValueW  = 16;
  localparam int unsigned StatusW = 2;

  // Command codes
  typedef enum logic [CmdW-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_REVERSE = 2'd1,
    CMD_DELETE  = 2'd2,
    CMD_DUMP    = 2'd3
  } cmd_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    STS_ELEM     = 2'd0,
    STS_EMPTY    = 2'd1,
    STS_ERROR    = 2'd2,
    STS_OVERFLOW = 2'd3
  } status_e;

endpackage
`default_nettype wire

// File: sv/rde_if.sv
`default_nettype none
interface rde_in_if;
  import rde_pkg::*;

  logic              valid;
  logic              ready;
  logic [CmdW-1:0]   command;
  logic [ValueW-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface rde_out_if;
  import rde_pkg::*;

  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [ValueW-1:0]  element;
  logic               last;

  modport source (output valid, output status, output element, output last, input ready);
  modport sink   (input valid, input status, input element, input last, output ready);
endinterface
`default_nettype wire

// File: sv/reversible_deque_engine_top.sv
`default_nettype none
// Bounded double-ended queue of up to DEPTH 16-bit elements with a lazy
// orientation flag. Load, reverse and delete are accepted back to back,
// also while an earlier result still waits at the output. A dump holds off
// input until its last result has entered the output register: a status or
// empty-list report is loaded once the output register is free, and a walk
// makes one store read a cycle while the output is not stalled, through
// the single read port of the element RAM, whose read is registered.
// The store needs no clearing pass after reset; entries are only read once
// written.
module reversible_deque_engine_top #(
  parameter int unsigned DEPTH = rde_pkg::DefaultDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rde_in_if.sink    in_i,
  rde_out_if.source out_o
);
  import rde_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [IdxW:0]   DepthS = (IdxW + 1)'(DEPTH);
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);
  localparam logic [CntW-1:0] OneC   = CntW'(1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_REPORT
  } state_e;

  // Physical slot of an offset from the head, modulo DEPTH
  function automatic logic [IdxW-1:0] slot_of(logic [IdxW-1:0] head, logic [IdxW-1:0] off);
    logic [IdxW:0] sum;
    sum = {1'b0, head} + {1'b0, off};
    if (sum >= DepthS) begin
      sum = sum - DepthS;
    end
    return sum[IdxW-1:0];
  endfunction

  state_e             state_q;
  logic [IdxW-1:0]    head_q;
  logic [CntW-1:0]    count_q;
  logic               rev_q;
  logic               err_q;
  logic               ovf_q;
  logic [CntW-1:0]    walk_q;
  logic               dv_q;
  logic               dv_last_q;
  status_e            rpt_q;
  logic               out_valid_q;
  logic [StatusW-1:0] out_status_q;
  logic [ValueW-1:0]  out_element_q;
  logic               out_last_q;

  logic               in_acc;
  cmd_e               cmd;
  logic               out_free;
  logic               out_load;
  logic               rd_en;
  logic [CntW-1:0]    rd_off;
  logic [IdxW-1:0]    rd_addr;
  logic [IdxW-1:0]    wr_addr;
  logic               wr_en;
  logic [ValueW-1:0]  rd_data;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign cmd        = cmd_e'(in_i.command);
  assign out_free   = !out_valid_q || out_o.ready;

  // New result enters the output register this cycle
  assign out_load = ((state_q == S_REPORT) || ((state_q == S_WALK) && dv_q)) && out_free;

  // Append at the physical back
  assign wr_addr = slot_of(head_q, count_q[IdxW-1:0]);
  assign wr_en   = in_acc && (cmd == CMD_LOAD) && !err_q && (count_q < DepthC);

  // Walk read: next read only when the previous data can move on
  assign rd_off  = rev_q ? (count_q - OneC - walk_q) : walk_q;
  assign rd_addr = slot_of(head_q, rd_off[IdxW-1:0]);
  assign rd_en   = (state_q == S_WALK) && (walk_q < count_q) && (!dv_q || out_free);

  rde_ram #(
    .WIDTH (ValueW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (in_i.value),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Control state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      head_q        <= '0;
      count_q       <= '0;
      rev_q         <= 1'b0;
      err_q         <= 1'b0;
      ovf_q         <= 1'b0;
      walk_q        <= '0;
      dv_q          <= 1'b0;
      dv_last_q     <= 1'b0;
      rpt_q         <= STS_EMPTY;
      out_valid_q   <= 1'b0;
      out_status_q  <= '0;
      out_element_q <= '0;
      out_last_q    <= 1'b0;
    end else begin
      // Drop a taken result
      if (out_valid_q && out_o.ready && !out_load) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (cmd == CMD_DUMP) begin
              walk_q <= '0;
              dv_q   <= 1'b0;
              if (err_q) begin
                rpt_q   <= STS_ERROR;
                state_q <= S_REPORT;
              end else if (ovf_q) begin
                rpt_q   <= STS_OVERFLOW;
                state_q <= S_REPORT;
              end else if (count_q == '0) begin
                rpt_q   <= STS_EMPTY;
                state_q <= S_REPORT;
              end else begin
                state_q <= S_WALK;
              end
            end else if (!err_q) begin
              case (cmd)
                CMD_LOAD: begin
                  if (count_q < DepthC) begin
                    count_q <= count_q + OneC;
                  end else begin
                    ovf_q <= 1'b1;
                  end
                end
                CMD_REVERSE: begin
                  rev_q <= !rev_q;
                end
                CMD_DELETE: begin
                  if (count_q == '0) begin
                    err_q <= 1'b1;
                  end else begin
                    if (!rev_q) begin
                      head_q <= slot_of(head_q, IdxW'(1));
                    end
                    count_q <= count_q - OneC;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end

        S_REPORT: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_status_q  <= rpt_q;
            out_element_q <= '0;
            out_last_q    <= 1'b1;
            head_q        <= '0;
            count_q       <= '0;
            rev_q         <= 1'b0;
            err_q         <= 1'b0;
            ovf_q         <= 1'b0;
            state_q       <= S_IDLE;
          end
        end

        S_WALK: begin
          // Advance the read side
          if (rd_en) begin
            walk_q    <= walk_q + OneC;
            dv_q      <= 1'b1;
            dv_last_q <= (walk_q + OneC == count_q);
          end else if (dv_q && out_free) begin
            dv_q <= 1'b0;
          end
          // Move read data into the output register
          if (dv_q && out_free) begin
            out_valid_q   <= 1'b1;
            out_status_q  <= STS_ELEM;
            out_element_q <= rd_data;
            out_last_q    <= dv_last_q;
            if (dv_last_q) begin
              head_q  <= '0;
              count_q <= '0;
              rev_q   <= 1'b0;
              err_q   <= 1'b0;
              ovf_q   <= 1'b0;
              state_q <= S_IDLE;
            end
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.status  = out_status_q;
  assign out_o.element = out_element_q;
  assign out_o.last    = out_last_q;

endmodule
`default_nettype wire

// File: sv/rde_ram.sv
`default_nettype none
module rde_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: sv/rde_checker.sv
`default_nettype none
module rde_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_i,
  input wire logic [rde_pkg::CmdW-1:0]    in_command_i,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic [rde_pkg::StatusW-1:0] out_status_i,
  input wire logic [rde_pkg::ValueW-1:0]  out_element_i,
  input wire logic                        out_last_i
);
  import rde_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i)
      && $stable(out_element_i) && $stable(out_last_i))
    else $error("stalled result changed");

  // Status reports carry a zero element
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != STS_ELEM) |-> (out_element_i == '0))
    else $error("status report with nonzero element");

  // Status reports end their dump
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != STS_ELEM) |-> out_last_i)
    else $error("status report without last");

  // A dump holds off input on the next cycle
  a_dump_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_command_i == CMD_DUMP) |=> !in_ready_i)
    else $error("input accepted right after a dump");

endmodule

bind reversible_deque_engine_top rde_checker u_rde_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_command_i  (in_i.command),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_status_i  (out_o.status),
  .out_element_i (out_o.element),
  .out_last_i    (out_o.last)
);
`default_nettype wire
